/* rtl/bfr_pkg.sv */
// ----------------------------------------------------------------------------
// bfr_pkg
// shared constants, codes and types of the msb-first bit field reader
// ----------------------------------------------------------------------------
package bfr_pkg;

    localparam int STORE_BYTES    = 256;
    localparam int MAX_FIELD_BITS = 32;
    localparam int ADDR_W         = $clog2(STORE_BYTES);
    localparam int CUR_W          = 12;
    localparam int ACC_W          = MAX_FIELD_BITS + 8;

    localparam logic [CUR_W-1:0] BIT_CAP = CUR_W'(STORE_BYTES * 8);

    // action codes
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_SEEK = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;
    localparam logic [1:0] ACT_NOP  = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  byte_address;
        logic [7:0]  data_byte;
        logic [10:0] seek_position;
        logic [5:0]  field_width;
    } t_item;

    typedef struct packed {
        logic [31:0] field_value;
        logic        range_error;
        logic [11:0] bits_remaining;
        logic [8:0]  byte_position;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

/* rtl/bfr_store.sv */
// ----------------------------------------------------------------------------
// bfr_store
// byte store, one write and one read port, registered read data
// ----------------------------------------------------------------------------
module bfr_store (
    input  logic              i_clk,
    input  bfr_pkg::t_mem_req i_req,
    output logic [7:0]        o_rdata
);
    import bfr_pkg::*;

    logic [7:0] mem [STORE_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bfr_ctrl.sv */
// ----------------------------------------------------------------------------
// bfr_ctrl
// sequencer: cursor, byte fetch over the store port, field extraction
// ----------------------------------------------------------------------------
module bfr_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_item_valid,
    output logic                       o_item_ready,
    input  bfr_pkg::t_item             i_item,
    input  logic [bfr_pkg::CUR_W-1:0]  i_bit_limit,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output bfr_pkg::t_result           o_res,
    output bfr_pkg::t_mem_req          o_mem,
    input  logic [7:0]                 i_mem_rdata
);
    import bfr_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_READ   = 2'd1;
    localparam logic [1:0] S_XTRACT = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    logic [1:0]        r_state,  n_state;
    logic [CUR_W-1:0]  r_cursor, n_cursor;
    logic [ADDR_W-1:0] r_base,   n_base;
    logic [2:0]        r_ofs,    n_ofs;
    logic [5:0]        r_width,  n_width;
    logic [2:0]        r_nbytes, n_nbytes;
    logic [2:0]        r_cnt,    n_cnt;
    logic [2:0]        r_got,    n_got;
    logic              r_pend,   n_pend;
    logic [ACC_W-1:0]  r_acc,    n_acc;
    logic [31:0]       r_value,  n_value;
    logic              r_err,    n_err;

    logic [CUR_W-1:0]  lim;
    logic [CUR_W:0]    rd_end;
    logic              rd_bad;
    logic [5:0]        nb_sum;
    logic              mem_re;
    logic [5:0]        sh_full;
    logic [ACC_W-1:0]  shifted;
    logic [32:0]       mask;
    logic [CUR_W:0]    pos_sum;

    // effective limit is capped at the store size
    assign lim = (i_bit_limit > BIT_CAP) ? BIT_CAP : i_bit_limit;

    assign rd_end = {1'b0, r_cursor} + (CUR_W + 1)'(i_item.field_width);
    assign rd_bad = (i_item.field_width > 6'(MAX_FIELD_BITS)) || (rd_end > {1'b0, lim});
    // bytes touched by the field
    assign nb_sum = {3'd0, r_cursor[2:0]} + i_item.field_width + 6'd7;

    assign mem_re = (r_state == S_READ) && (r_cnt != r_nbytes);

    assign sh_full = {r_nbytes, 3'b000} - {3'd0, r_ofs} - r_width;
    assign shifted = r_acc >> sh_full[2:0];
    assign mask    = (33'd1 << r_width) - 33'd1;

    always_comb begin
        n_state  = r_state;
        n_cursor = r_cursor;
        n_base   = r_base;
        n_ofs    = r_ofs;
        n_width  = r_width;
        n_nbytes = r_nbytes;
        n_cnt    = r_cnt;
        n_got    = r_got;
        n_acc    = r_acc;
        n_value  = r_value;
        n_err    = r_err;
        n_pend   = mem_re;
        case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    n_value = '0;
                    n_err   = 1'b0;
                    n_state = S_DONE;
                    case (i_item.action)
                        ACT_SEEK: begin
                            if ({1'b0, i_item.seek_position} < lim) begin
                                n_cursor = {1'b0, i_item.seek_position};
                            end else begin
                                n_err = 1'b1;
                            end
                        end
                        ACT_READ: begin
                            if (rd_bad) begin
                                n_err = 1'b1;
                            end else if (i_item.field_width != 6'd0) begin
                                n_base   = r_cursor[ADDR_W+2:3];
                                n_ofs    = r_cursor[2:0];
                                n_width  = i_item.field_width;
                                n_nbytes = nb_sum[5:3];
                                n_cnt    = '0;
                                n_got    = '0;
                                n_acc    = '0;
                                n_state  = S_READ;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_READ: begin
                if (mem_re) begin
                    n_cnt = r_cnt + 3'd1;
                end
                if (r_pend) begin
                    n_acc = {r_acc[ACC_W-9:0], i_mem_rdata};
                    n_got = r_got + 3'd1;
                    if ((r_got + 3'd1) == r_nbytes) begin
                        n_state = S_XTRACT;
                    end
                end
            end
            S_XTRACT: begin
                n_value  = shifted[31:0] & mask[31:0];
                n_cursor = r_cursor + CUR_W'(r_width);
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cursor <= '0;
            r_pend   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_pend   <= n_pend;
        end
        r_base   <= n_base;
        r_ofs    <= n_ofs;
        r_width  <= n_width;
        r_nbytes <= n_nbytes;
        r_cnt    <= n_cnt;
        r_got    <= n_got;
        r_acc    <= n_acc;
        r_value  <= n_value;
        r_err    <= n_err;
    end

    assign o_item_ready = (r_state == S_IDLE);

    // store port: loads write on acceptance, reads issue one byte a cycle
    assign o_mem.we    = (r_state == S_IDLE) && i_item_valid && (i_item.action == ACT_LOAD);
    assign o_mem.waddr = i_item.byte_address[ADDR_W-1:0];
    assign o_mem.wdata = i_item.data_byte;
    assign o_mem.re    = mem_re;
    assign o_mem.raddr = r_base + ADDR_W'(r_cnt);

    assign pos_sum = {1'b0, r_cursor} + (CUR_W + 1)'(7);

    assign o_res_valid          = (r_state == S_DONE);
    assign o_res.field_value    = r_value;
    assign o_res.range_error    = r_err;
    assign o_res.bits_remaining = (r_cursor < lim) ? (lim - r_cursor) : '0;
    assign o_res.byte_position  = pos_sum[11:3];

endmodule

/* rtl/msb_first_bit_field_reader.sv */
// ----------------------------------------------------------------------------
// msb_first_bit_field_reader
// reads msb-first bit fields of 1 to 32 bits out of a loaded byte store
// ----------------------------------------------------------------------------
// Each request loads a byte into the 256-byte store, seeks the bit cursor, or
// reads a field of up to 32 bits starting at the cursor, bit 7 of each byte
// first, and answers with exactly one result. A read that touches n bytes
// (1 to 5) fetches them over the single read port of the store, which hands
// out one byte per cycle with registered read data, after which the S_XTRACT
// state shifts and masks the field. One request is in work at a time; a
// finished result sits in the output register, so the next request is taken
// while the previous result waits for the sink. The user must write the bit
// limit only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module msb_first_bit_field_reader (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // byte_address[7:0], data_byte[15:8],
                                     // seek_position[26:16], field_width[32:27]
    input  logic [1:0]  i_s_tuser,   // action[1:0]
    // result channel
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // field_value[31:0], bits_remaining[43:32],
                                     // byte_position[52:44]
    output logic        o_m_tuser,   // range_error[0]
    // bit limit register
    input  logic        i_cfg_wen,
    input  logic [11:0] i_cfg_wdata
);
    import bfr_pkg::*;

    logic [CUR_W-1:0] r_bit_limit;
    logic             r_out_valid;
    t_result          r_out;

    t_item            item;
    t_result          res;
    logic             res_valid;
    logic             res_ready;
    t_mem_req         mem_req;
    logic [7:0]       mem_rdata;

    // unpack the request
    assign item.action        = i_s_tuser;
    assign item.byte_address  = i_s_tdata[7:0];
    assign item.data_byte     = i_s_tdata[15:8];
    assign item.seek_position = i_s_tdata[26:16];
    assign item.field_width   = i_s_tdata[32:27];

    // bit limit, reset to the full store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_limit <= BIT_CAP;
        end else if (i_cfg_wen) begin
            r_bit_limit <= i_cfg_wdata;
        end
    end

    bfr_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_s_tvalid),
        .o_item_ready (o_s_tready),
        .i_item       (item),
        .i_bit_limit  (r_bit_limit),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res),
        .o_mem        (mem_req),
        .i_mem_rdata  (mem_rdata)
    );

    bfr_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // output register: frees the sequencer while a result waits
    assign res_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out.byte_position, r_out.bits_remaining,
                         r_out.field_value};
    assign o_m_tuser  = r_out.range_error;

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the msb-first bit field reader
// ----------------------------------------------------------------------------
// Drives load, seek, read and no-op requests into the block and checks each
// result against a cycle-free predictor of the byte store, bit cursor and bit
// limit. A short directed run covers the edges first: five-byte straddles,
// zero and over-wide reads, reads and seeks at the limit, and a limit below
// the cursor. After that the whole store is loaded and random traffic runs
// under a series of bit limits. Both handshakes idle at random, and one
// phase runs with no idling at all.
// ----------------------------------------------------------------------------
module testbench;
    import bfr_pkg::*;

    localparam int IDLE_PCT      = 20;
    localparam int PHASE_ITEMS   = 240;
    localparam int CALM_PHASE    = 3;
    localparam int DRAIN_CYCLES  = 20;
    localparam int SHOWN_ERRORS  = 10;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [55:0] o_m_tdata;
    logic        o_m_tuser;
    logic        i_cfg_wen   = 1'b0;
    logic [11:0] i_cfg_wdata = '0;

    // request on the bus, packed into tdata and tuser
    t_item bus_request = '0;
    assign i_s_tdata = {7'd0, bus_request.field_width, bus_request.seek_position,
                        bus_request.data_byte, bus_request.byte_address};
    assign i_s_tuser = bus_request.action;

    // requests waiting to go out, and results the block still owes
    t_item   pending_requests[$];
    t_result owed_results[$];

    // predictor state: store image, cursor and written bit limit
    logic [7:0]  store_image [STORE_BYTES];
    logic [11:0] cursor_q = '0;
    logic [11:0] limit_q  = 12'd2048;

    int idle_pct       = IDLE_PCT;
    int mismatch_count = 0;
    int results_seen   = 0;
    int loads_seen     = 0;
    int seeks_seen     = 0;
    int reads_seen     = 0;
    int reads_refused  = 0;
    int nops_seen      = 0;
    int limits_used    = 0;

    msb_first_bit_field_reader i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // written limit clipped to the store size
    function automatic int unsigned effective_limit();
        return (limit_q < BIT_CAP) ? limit_q : BIT_CAP;
    endfunction

    // applies one request to the predictor state and returns its result
    function automatic t_result apply_request(t_item rq);
        t_result     res;
        int unsigned lim;
        int unsigned pos;
        int unsigned i;
        res = '0;
        lim = effective_limit();
        case (rq.action)
            ACT_LOAD: begin
                store_image[rq.byte_address] = rq.data_byte;
                loads_seen++;
            end
            ACT_SEEK: begin
                seeks_seen++;
                if (rq.seek_position < lim) begin
                    cursor_q = rq.seek_position;
                end else begin
                    res.range_error = 1'b1;
                end
            end
            ACT_READ: begin
                reads_seen++;
                // over-wide fields and fields running past the limit are refused
                if (rq.field_width > MAX_FIELD_BITS || cursor_q + rq.field_width > lim) begin
                    res.range_error = 1'b1;
                    reads_refused++;
                end else begin
                    // first bit read lands in the most significant position
                    for (i = 0; i < rq.field_width; i++) begin
                        pos = cursor_q + i;
                        res.field_value = {res.field_value[30:0],
                                           store_image[pos >> 3][7 - (pos % 8)]};
                    end
                    cursor_q = cursor_q + rq.field_width;
                end
            end
            default: begin
                nops_seen++;
            end
        endcase
        // remaining bits saturate at zero when the limit sits below the cursor
        res.bits_remaining = (cursor_q < lim) ? 12'(lim - cursor_q) : 12'd0;
        res.byte_position  = 9'((int'(cursor_q) + 7) >> 3);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // request builders
    // ------------------------------------------------------------------------

    function automatic t_item make_request(logic [1:0] action, logic [7:0] addr,
                                           logic [7:0] data, logic [10:0] seek,
                                           logic [5:0] width);
        t_item rq;
        rq.action        = action;
        rq.byte_address  = addr;
        rq.data_byte     = data;
        rq.seek_position = seek;
        rq.field_width   = width;
        return rq;
    endfunction

    // random request with random unused fields; only safe once the store is full
    function automatic t_item random_request();
        t_item       rq;
        int unsigned lim;
        int unsigned roll;
        int unsigned span;
        rq = make_request(2'($urandom_range(3)), 8'($urandom_range(255)),
                          8'($urandom_range(255)), 11'($urandom_range(2047)),
                          6'($urandom_range(63)));
        lim  = effective_limit();
        roll = $urandom_range(99);
        if (roll < 15) begin
            rq.action = ACT_LOAD;
        end else if (roll < 32) begin
            rq.action = ACT_SEEK;
            roll = $urandom_range(99);
            if (lim > 0 && roll < 30) begin
                // land close to the end so reads run into the limit
                span = (lim - 1 < 64) ? lim - 1 : 64;
                rq.seek_position = 11'(lim - 1 - $urandom_range(span));
            end else if (lim > 0 && roll < 85) begin
                rq.seek_position = 11'($urandom_range(lim - 1));
            end
            // otherwise keep the random position, often out of range
        end else if (roll < 95) begin
            rq.action = ACT_READ;
            roll = $urandom_range(99);
            if (roll < 8) begin
                rq.field_width = 6'd0;
            end else if (roll < 16) begin
                rq.field_width = 6'($urandom_range(63, MAX_FIELD_BITS + 1));
            end else if (roll < 26) begin
                rq.field_width = 6'(MAX_FIELD_BITS);
            end else begin
                rq.field_width = 6'($urandom_range(MAX_FIELD_BITS, 1));
            end
        end else begin
            rq.action = ACT_NOP;
        end
        return rq;
    endfunction

    // ------------------------------------------------------------------------
    // clock, reset and watchdog
    // ------------------------------------------------------------------------

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("run timed out with %0d results owed", owed_results.size());
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // request driver: takes the next pending request, idles at random
    // ------------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            // request taken at this edge: predict its result now
            if (i_s_tvalid && o_s_tready) begin
                owed_results.push_back(apply_request(bus_request));
            end
            // bus is free when nothing is shown or the shown request was taken
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    bus_request <= pending_requests.pop_front();
                    i_s_tvalid  <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor: compares each result with the oldest owed one
    // ------------------------------------------------------------------------

    always @(posedge i_clk) begin : result_check
        t_result seen;
        t_result want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                seen.field_value    = o_m_tdata[31:0];
                seen.range_error    = o_m_tuser;
                seen.bits_remaining = o_m_tdata[43:32];
                seen.byte_position  = o_m_tdata[52:44];
                results_seen++;
                if (owed_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOWN_ERRORS) begin
                        $display("result %0d arrived with none owed: value %h err %b",
                                 results_seen, seen.field_value, seen.range_error);
                    end
                end else begin
                    want = owed_results.pop_front();
                    if (seen.field_value    !== want.field_value    ||
                        seen.range_error    !== want.range_error    ||
                        seen.bits_remaining !== want.bits_remaining ||
                        seen.byte_position  !== want.byte_position) begin
                        mismatch_count++;
                        if (mismatch_count <= SHOWN_ERRORS) begin
                            $display("result %0d: expected value %h err %b rem %0d pos %0d",
                                     results_seen, want.field_value, want.range_error,
                                     want.bits_remaining, want.byte_position);
                            $display("result %0d:      got value %h err %b rem %0d pos %0d",
                                     results_seen, seen.field_value, seen.range_error,
                                     seen.bits_remaining, seen.byte_position);
                        end
                    end
                end
            end
            i_m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // sequencing
    // ------------------------------------------------------------------------

    // block is idle once every request went out and every result came back;
    // sampled between edges so the driver and monitor updates have settled
    task automatic wait_idle();
        while (pending_requests.size() != 0 || i_s_tvalid || owed_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_bit_limit(input logic [11:0] value);
        @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        limit_q = value;
        limits_used++;
    endtask

    initial begin : stimulus
        int          order[STORE_BYTES];
        int          tmp;
        int unsigned j;
        t_item       rq;
        logic [11:0] phase_limits[7];

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: full limit, a few known bytes near both ends of the store
        write_bit_limit(12'd2048);
        pending_requests.push_back(make_request(ACT_LOAD, 8'd0, 8'hA5, 11'd0, 6'd0));
        pending_requests.push_back(make_request(ACT_LOAD, 8'd1, 8'h3C, 11'd0, 6'd0));
        pending_requests.push_back(make_request(ACT_LOAD, 8'd2, 8'hFF, 11'd0, 6'd0));
        pending_requests.push_back(make_request(ACT_LOAD, 8'd3, 8'h00, 11'd0, 6'd0));
        pending_requests.push_back(make_request(ACT_LOAD, 8'd4, 8'h96, 11'd0, 6'd0));
        pending_requests.push_back(make_request(ACT_LOAD, 8'hFF, 8'h81, 11'h7FF, 6'h3F));
        // zero-width read, then a full word on a byte boundary
        pending_requests.push_back(make_request(ACT_READ, 8'd0, 8'd0, 11'd0, 6'd0));
        pending_requests.push_back(make_request(ACT_READ, 8'd0, 8'd0, 11'd0, 6'd32));
        // full word straddling five bytes
        pending_requests.push_back(make_request(ACT_SEEK, 8'd0, 8'd0, 11'd3, 6'd0));
        pending_requests.push_back(make_request(ACT_READ, 8'd0, 8'd0, 11'd0, 6'd32));
        // short field across a byte boundary
        pending_requests.push_back(make_request(ACT_SEEK, 8'd0, 8'd0, 11'd7, 6'd0));
        pending_requests.push_back(make_request(ACT_READ, 8'd0, 8'd0, 11'd0, 6'd3));
        // over-wide reads are refused
        pending_requests.push_back(make_request(ACT_READ, 8'd0, 8'd0, 11'd0, 6'd33));
        pending_requests.push_back(make_request(ACT_READ, 8'd0, 8'd0, 11'd0, 6'd63));
        // last bit of the store, then zero-width and one-bit reads at the limit
        pending_requests.push_back(make_request(ACT_SEEK, 8'd0, 8'd0, 11'd2047, 6'd0));
        pending_requests.push_back(make_request(ACT_READ, 8'd0, 8'd0, 11'd0, 6'd1));
        pending_requests.push_back(make_request(ACT_READ, 8'd0, 8'd0, 11'd0, 6'd0));
        pending_requests.push_back(make_request(ACT_READ, 8'd0, 8'd0, 11'd0, 6'd1));
        // no-op with every field bit set
        pending_requests.push_back(make_request(ACT_NOP, 8'hFF, 8'hFF, 11'h7FF, 6'h3F));
        pending_requests.push_back(make_request(ACT_SEEK, 8'd0, 8'd0, 11'd0, 6'd0));
        wait_idle();

        // small limit: seek just below and at it, read running over it
        write_bit_limit(12'd20);
        pending_requests.push_back(make_request(ACT_SEEK, 8'd0, 8'd0, 11'd19, 6'd0));
        pending_requests.push_back(make_request(ACT_SEEK, 8'd0, 8'd0, 11'd20, 6'd0));
        pending_requests.push_back(make_request(ACT_READ, 8'd0, 8'd0, 11'd0, 6'd2));
        pending_requests.push_back(make_request(ACT_READ, 8'd0, 8'd0, 11'd0, 6'd1));
        pending_requests.push_back(make_request(ACT_READ, 8'd0, 8'd0, 11'd0, 6'd0));
        wait_idle();

        // limit below the cursor: even a zero-width read fails
        write_bit_limit(12'd8);
        pending_requests.push_back(make_request(ACT_READ, 8'd0, 8'd0, 11'd0, 6'd0));
        pending_requests.push_back(make_request(ACT_READ, 8'd0, 8'd0, 11'd0, 6'd1));
        pending_requests.push_back(make_request(ACT_SEEK, 8'd0, 8'd0, 11'd7, 6'd0));
        wait_idle();

        // load every byte in shuffled order, with seeks and no-ops mixed in
        write_bit_limit(12'hFFF);
        foreach (order[i]) order[i] = i;
        for (int i = STORE_BYTES - 1; i > 0; i--) begin
            j        = $urandom_range(i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        foreach (order[i]) begin
            if ($urandom_range(99) < 15) begin
                rq = random_request();
                if (rq.action == ACT_READ || rq.action == ACT_LOAD) rq.action = ACT_NOP;
                pending_requests.push_back(rq);
            end
            rq = random_request();
            rq.action       = ACT_LOAD;
            rq.byte_address = 8'(order[i]);
            pending_requests.push_back(rq);
        end

        // random traffic under a range of limits; sender drains between phases
        phase_limits[0] = 12'd2048;
        phase_limits[1] = 12'd0;
        phase_limits[2] = 12'd1;
        phase_limits[3] = 12'hFFF;
        phase_limits[4] = 12'($urandom_range(2047, 2));
        phase_limits[5] = 12'd2047;
        phase_limits[6] = 12'($urandom_range(4095));
        foreach (phase_limits[p]) begin
            wait_idle();
            write_bit_limit(phase_limits[p]);
            idle_pct = (p == CALM_PHASE) ? 0 : IDLE_PCT;
            repeat (PHASE_ITEMS) pending_requests.push_back(random_request());
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d loads, %0d seeks, %0d reads (%0d refused), %0d no-ops",
                 loads_seen, seeks_seen, reads_seen, reads_refused, nops_seen);
        $display("checked %0d results under %0d bit limit writes, %0d mismatches",
                 results_seen, limits_used, mismatch_count);
        if (mismatch_count == 0 && owed_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/bfr_pkg.sv
rtl/bfr_store.sv
rtl/bfr_ctrl.sv
rtl/msb_first_bit_field_reader.sv
sim/testbench.sv
